FILE: design/rfp_pkg.sv
// Shared types and constants for the RFID ASCII frame parser.
package rfp_pkg;

    localparam int FRAME_CHARS = 12;
    localparam int BYTE_W      = 8;
    localparam int CARD_W      = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_CARD = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] HEX_TEN       = 8'd10;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [CARD_W-1:0] target_card;
    } rfp_cfg_t;

    typedef struct packed {
        logic              checksum_ok;
        logic [CARD_W-1:0] card_number;
        logic              card_match;
    } rfp_result_t;

endpackage

FILE: design/rfp_if.sv
// Channel interfaces: received bytes, parse results and register writes.
interface rfp_byte_if
    import rfp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfp_result_if
    import rfp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              checksum_ok;
    logic [CARD_W-1:0] card_number;
    logic              card_match;

    modport source (output valid, output checksum_ok, output card_number,
                    output card_match, input ready);
    modport sink (input valid, input checksum_ok, input card_number,
                  input card_match, output ready);
endinterface

interface rfp_cfg_if
    import rfp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/rfp_frame_fsm.sv
// Frame state machine: start detect, hex decode, checksum and card shift.
module rfp_frame_fsm
    import rfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  rfp_cfg_t          cfg,
    output logic              result_valid,
    output rfp_result_t       result
);

    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_COLLECT  = 2'd1;
    localparam logic [1:0] PH_WAIT_END = 2'd2;

    localparam logic [3:0] LAST_CHAR_COUNT = 4'(FRAME_CHARS);

    logic [1:0]        phase_reg, phase_next;
    logic [3:0]        char_count_reg, char_count_next;
    logic [3:0]        high_nibble_reg, high_nibble_next;
    logic [BYTE_W-1:0] xor_sum_reg, xor_sum_next;
    logic [CARD_W-1:0] card_shift_reg, card_shift_next;
    logic [BYTE_W-1:0] check_byte_reg, check_byte_next;

    logic [BYTE_W-1:0] digit;
    logic [BYTE_W-1:0] pair_value;
    logic [2:0]        pair_idx;
    logic [3:0]        count_inc;
    logic              sum_ok;

    always_comb
    begin
        if (rx_byte >= ASCII_UPPER_A)
        begin
            digit = rx_byte - ASCII_UPPER_A + HEX_TEN;
        end
        else
        begin
            digit = rx_byte - ASCII_ZERO;
        end
    end

    assign pair_value = {high_nibble_reg, 4'b0000} + digit;
    assign pair_idx   = char_count_reg[3:1];
    assign count_inc  = char_count_reg + 4'd1;
    assign sum_ok     = (xor_sum_reg == check_byte_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        char_count_next  = char_count_reg;
        high_nibble_next = high_nibble_reg;
        xor_sum_next     = xor_sum_reg;
        card_shift_next  = card_shift_reg;
        check_byte_next  = check_byte_reg;
        result_valid     = 1'b0;
        result.checksum_ok = sum_ok;
        result.card_number = sum_ok ? card_shift_reg : '0;
        result.card_match  = sum_ok && (card_shift_reg == cfg.target_card);

        if (accept)
        begin
            unique case (phase_reg)
                PH_COLLECT:
                begin
                    if ((rx_byte == cfg.start_byte) || (rx_byte == cfg.end_byte))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        if (!char_count_reg[0])
                        begin
                            high_nibble_next = digit[3:0];
                        end
                        else
                        begin
                            if (pair_idx < 3'd5)
                            begin
                                xor_sum_next = xor_sum_reg ^ pair_value;
                            end
                            if ((pair_idx >= 3'd1) && (pair_idx <= 3'd4))
                            begin
                                card_shift_next = {card_shift_reg[CARD_W-BYTE_W-1:0],
                                                   pair_value};
                            end
                            if (pair_idx == 3'd5)
                            begin
                                check_byte_next = pair_value;
                            end
                        end
                        char_count_next = count_inc;
                        if (count_inc >= LAST_CHAR_COUNT)
                        begin
                            phase_next = PH_WAIT_END;
                        end
                    end
                end
                PH_WAIT_END:
                begin
                    phase_next   = PH_IDLE;
                    result_valid = (rx_byte == cfg.end_byte);
                end
                default:
                begin
                    // idle, and the unused code behaves as idle
                    if (rx_byte == cfg.start_byte)
                    begin
                        phase_next       = PH_COLLECT;
                        char_count_next  = '0;
                        high_nibble_next = '0;
                        xor_sum_next     = '0;
                        card_shift_next  = '0;
                        check_byte_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            char_count_reg  <= '0;
            high_nibble_reg <= '0;
            xor_sum_reg     <= '0;
            card_shift_reg  <= '0;
            check_byte_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            char_count_reg  <= char_count_next;
            high_nibble_reg <= high_nibble_next;
            xor_sum_reg     <= xor_sum_next;
            card_shift_reg  <= card_shift_next;
            check_byte_reg  <= check_byte_next;
        end
    end

endmodule

FILE: design/rfp_frame_parser_core_top.sv
// Top level of the RFID ASCII frame parser: registers, FSM and result buffer.
//
// Usage:
//   rx  : one received serial byte per beat (valid/ready).
//   res : one beat per completed frame carrying checksum_ok, card_number
//         (zero on a bad checksum) and card_match against target_card.
//   cfg : register writes; index 0 start_byte, 1 end_byte, 2 target_card.
//         Always ready; write only while no frame is in progress.
// Throughput: one rx byte per cycle while the skid entry is free. Each byte
//   updates the frame registers in the cycle it is accepted; the decode and
//   XOR into the frame registers and the compare into the result register
//   are combinational.
// Stall: a two-deep result buffer (output register plus skid) holds results
//   while res.ready is low; rx stays ready until the skid entry is full,
//   which only happens after two frames complete under a stall.
// Reset: rst_n clears the frame state and result buffer and loads
//   start_byte = 0x02, end_byte = 0x03, target_card = 0.
module rfid_ascii_frame_parser_core
    import rfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rfp_byte_if.sink     rx,
    rfp_result_if.source res,
    rfp_cfg_if.sink      cfg
);

    rfp_cfg_t    cfg_reg;
    logic        rx_accept;
    logic        result_valid;
    rfp_result_t result;

    logic        out_valid_reg;
    rfp_result_t out_data_reg;
    logic        skid_valid_reg;
    rfp_result_t skid_data_reg;
    logic        out_fire;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= START_BYTE_RST;
            cfg_reg.end_byte    <= END_BYTE_RST;
            cfg_reg.target_card <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_START_BYTE:  cfg_reg.start_byte  <= cfg.data[BYTE_W-1:0];
                CFG_END_BYTE:    cfg_reg.end_byte    <= cfg.data[BYTE_W-1:0];
                CFG_TARGET_CARD: cfg_reg.target_card <= cfg.data[CARD_W-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    assign rx.ready  = !skid_valid_reg;
    assign rx_accept = rx.valid && rx.ready;

    rfp_frame_fsm u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (rx_accept),
        .rx_byte      (rx.rx_byte),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    assign out_fire = out_valid_reg && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (result_valid)
        begin
            // skid is empty here, since rx is only taken with skid free
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.checksum_ok = out_data_reg.checksum_ok;
    assign res.card_number = out_data_reg.card_number;
    assign res.card_match  = out_data_reg.card_match;

endmodule

FILE: design/rfp_checker.sv
// Port-level assertions for the frame parser, bound to the top level.
module rfp_checker
    import rfp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rx_valid,
    input logic              rx_ready,
    input logic              res_valid,
    input logic              res_ready,
    input logic              res_checksum_ok,
    input logic [CARD_W-1:0] res_card_number,
    input logic              res_card_match
);

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // a match is only reported on a good checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_card_match |-> res_checksum_ok)
        else $error("card match without good checksum");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_checksum_ok |-> (res_card_number == '0))
        else $error("card number not zero on bad checksum");

    // a fresh result needs an rx beat taken in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready))
        else $error("result appeared without a preceding rx beat");

endmodule

bind rfid_ascii_frame_parser_core rfp_checker u_rfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_valid        (rx.valid),
    .rx_ready        (rx.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_checksum_ok (res.checksum_ok),
    .res_card_number (res.card_number),
    .res_card_match  (res.card_match)
);

FILE: tb/rfp_frame_checker.sv
// Frame checker: shadows the registers, predicts each parse result and compares.
module rfp_frame_checker
    import rfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    rfp_byte_if    rx,
    rfp_result_if  res,
    rfp_cfg_if     cfg,
    output int     errors,
    output int     pending,
    output logic   parser_idle
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_COLLECT  = 2'd1,
        PH_WAIT_END = 2'd2
    } parse_phase_e;

    logic [BYTE_W-1:0] start_val;
    logic [BYTE_W-1:0] end_val;
    logic [CARD_W-1:0] target_val;

    parse_phase_e      phase;
    logic [3:0]        nchars;
    logic [3:0]        hi_nib;
    logic [BYTE_W-1:0] xsum;
    logic [BYTE_W-1:0] sum_byte;
    logic [CARD_W-1:0] card_acc;

    rfp_result_t       expected_reads[$];

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Advance the frame parser by one received byte.
    task automatic parse_byte(input logic [BYTE_W-1:0] b, output bit got,
                              output rfp_result_t r);
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] v;
        logic [2:0]        pair;
        got = 1'b0;
        r = '0;
        case (phase)
            PH_COLLECT:
            begin
                if (b == start_val || b == end_val)
                begin
                    phase = PH_IDLE;
                end
                else
                begin
                    d = (b >= ASCII_UPPER_A) ? b - ASCII_UPPER_A + HEX_TEN : b - ASCII_ZERO;
                    if (!nchars[0])
                    begin
                        hi_nib = d[3:0];
                    end
                    else
                    begin
                        v = {hi_nib, 4'h0} + d;
                        pair = nchars[3:1];
                        if (pair < 3'd5)
                            xsum ^= v;
                        if (pair >= 3'd1 && pair <= 3'd4)
                            card_acc = {card_acc[CARD_W-9:0], v};
                        if (pair == 3'd5)
                            sum_byte = v;
                    end
                    nchars = nchars + 4'd1;
                    if (nchars >= FRAME_CHARS)
                        phase = PH_WAIT_END;
                end
            end
            PH_WAIT_END:
            begin
                phase = PH_IDLE;
                if (b == end_val)
                begin
                    got = 1'b1;
                    r.checksum_ok = (xsum == sum_byte);
                    r.card_number = r.checksum_ok ? card_acc : '0;
                    r.card_match  = r.checksum_ok && (r.card_number == target_val);
                end
            end
            default:
            begin
                if (b == start_val)
                begin
                    nchars   = '0;
                    hi_nib   = '0;
                    xsum     = '0;
                    sum_byte = '0;
                    card_acc = '0;
                    phase    = PH_COLLECT;
                end
                else
                begin
                    phase = PH_IDLE;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rfp_result_t want;
        rfp_result_t got_res;
        bit          got;
        if (!rst_n)
        begin
            start_val  = START_BYTE_RST;
            end_val    = END_BYTE_RST;
            target_val = '0;
            phase      = PH_IDLE;
            nchars     = '0;
            hi_nib     = '0;
            xsum       = '0;
            sum_byte   = '0;
            card_acc   = '0;
            expected_reads.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_START_BYTE:  start_val  = cfg.data[BYTE_W-1:0];
                    CFG_END_BYTE:    end_val    = cfg.data[BYTE_W-1:0];
                    CFG_TARGET_CARD: target_val = cfg.data[CARD_W-1:0];
                    default: ;
                endcase
            end
            // Retire a result beat before the byte of this edge can queue a new one.
            if (res.valid && res.ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    report($sformatf("unexpected result ok=%0b card=%08h match=%0b",
                                     res.checksum_ok, res.card_number, res.card_match));
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (res.checksum_ok !== want.checksum_ok)
                        report($sformatf("checksum_ok %0b, want %0b",
                                         res.checksum_ok, want.checksum_ok));
                    if (res.card_number !== want.card_number)
                        report($sformatf("card_number %08h, want %08h",
                                         res.card_number, want.card_number));
                    if (res.card_match !== want.card_match)
                        report($sformatf("card_match %0b, want %0b",
                                         res.card_match, want.card_match));
                end
            end
            if (rx.valid && rx.ready)
            begin
                parse_byte(rx.rx_byte, got, got_res);
                if (got)
                    expected_reads.push_back(got_res);
            end
        end
        pending     = expected_reads.size();
        parser_idle = (phase == PH_IDLE);
    end

    initial
    begin
        errors      = 0;
        pending     = 0;
        parser_idle = 1'b1;
    end

endmodule

FILE: tb/testbench.sv
// Top of the frame parser bench: clock, reset, byte and register stimulus, verdict.
module testbench
    import rfp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BYTES  = 240;
    localparam int NUM_PHASES   = 8;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_JUNK,
        FR_EARLY_CUT,
        FR_WRONG_CLOSE
    } frame_kind_e;

    logic clk = 1'b0;
    logic rst_n;

    rfp_byte_if   rx_ch ();
    rfp_result_if res_ch ();
    rfp_cfg_if    cfg_ch ();

    int   errors;
    int   pending;
    logic parser_idle;

    int   cycles = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    bit   holding = 1'b0;
    event hold_go;

    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_end;
    logic [CARD_W-1:0] cur_target;
    int                bytes_sent = 0;

    rfid_ascii_frame_parser_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    rfp_frame_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_ch),
        .res         (res_ch),
        .cfg         (cfg_ch),
        .errors      (errors),
        .pending     (pending),
        .parser_idle (parser_idle)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result sink: random stalls, plus a long hold-off when requested.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= !holding && ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? ASCII_ZERO + n : ASCII_UPPER_A + n - HEX_TEN;
    endfunction

    // Offer one byte; valid stays high on return.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [CARD_W-1:0] t);
        write_reg(CFG_START_BYTE, CFG_DATA_W'(s));
        write_reg(CFG_END_BYTE, CFG_DATA_W'(e));
        write_reg(CFG_TARGET_CARD, CFG_DATA_W'(t));
        cfg_ch.valid <= 1'b0;
        cur_start  = s;
        cur_end    = e;
        cur_target = t;
    endtask

    // Drain all results and push the parser back to idle with end bytes.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        forever
        begin
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            if (parser_idle && pending == 0)
                return;
            send_byte(cur_end);
            rx_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_frame(input logic [CARD_W-1:0] card, input frame_kind_e kind);
        logic [BYTE_W-1:0] fb [6];
        logic [BYTE_W-1:0] ch [FRAME_CHARS];
        logic [BYTE_W-1:0] close_b;
        int                cut_at;
        fb[0] = BYTE_W'($urandom);
        for (int k = 1; k <= 4; k++)
            fb[k] = card[8*(4-k) +: 8];
        fb[5] = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4];
        if (kind == FR_BAD_SUM)
            fb[5] ^= BYTE_W'($urandom_range(255, 1));
        for (int i = 0; i < 6; i++)
        begin
            ch[2*i]   = hex_char(fb[i][7:4]);
            ch[2*i+1] = hex_char(fb[i][3:0]);
        end
        if (kind == FR_JUNK)
            for (int i = 0; i < FRAME_CHARS; i++)
                if ($urandom_range(99) < 30)
                    ch[i] = BYTE_W'($urandom);
        cut_at = $urandom_range(FRAME_CHARS - 1, 0);
        send_byte(cur_start);
        for (int i = 0; i < FRAME_CHARS; i++)
        begin
            if (kind == FR_EARLY_CUT && i == cut_at)
            begin
                send_byte($urandom_range(1) ? cur_start : cur_end);
                return;
            end
            send_byte(ch[i]);
        end
        if (kind == FR_WRONG_CLOSE)
        begin
            close_b = ($urandom_range(1) && cur_start != cur_end) ? cur_start
                                                                   : BYTE_W'($urandom);
            if (close_b == cur_end)
                close_b = ~cur_end;
            send_byte(close_b);
        end
        else
        begin
            send_byte(cur_end);
        end
    endtask

    task automatic random_frames(input int n_bytes);
        int                 pick;
        logic [CARD_W-1:0]  card;
        frame_kind_e        kind;
        int                 stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                card = cur_target;
            else if (pick < 35)
                card = '0;
            else if (pick < 45)
                card = '1;
            else
                card = $urandom;
            pick = $urandom_range(99);
            if (pick < 60)
                kind = FR_GOOD;
            else if (pick < 75)
                kind = FR_BAD_SUM;
            else if (pick < 85)
                kind = FR_JUNK;
            else if (pick < 93)
                kind = FR_EARLY_CUT;
            else
                kind = FR_WRONG_CLOSE;
            send_frame(card, kind);
            // Line noise between frames.
            if ($urandom_range(99) < 10)
                repeat ($urandom_range(3, 1)) send_byte(BYTE_W'($urandom));
        end
    endtask

    initial
    begin
        string good_chars;
        good_chars = "FF00000000FF";
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(START_BYTE_RST, END_BYTE_RST, '0);

        // Directed: all-F/all-0 frame matching target zero, early end, early start,
        // idle bytes at the extremes.
        send_byte(cur_start);
        for (int i = 0; i < FRAME_CHARS; i++)
            send_byte(good_chars[i]);
        send_byte(cur_end);
        send_byte(cur_start);
        send_byte("1");
        send_byte(cur_end);
        send_byte(cur_start);
        send_byte("2");
        send_byte(cur_start);
        send_byte("Z");
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: write_cfg(START_BYTE_RST, END_BYTE_RST, '0);
                1: write_cfg(8'h00, 8'hFF, '1);
                2: write_cfg(8'hFF, 8'h00, $urandom);
                3: write_cfg(8'h55, 8'h55, $urandom);
                default: write_cfg(BYTE_W'($urandom), BYTE_W'($urandom), $urandom);
            endcase
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 72; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 72; end
                default: begin send_idle = 32; recv_stall = 32; end
            endcase
            // Hold off the sink while bytes keep coming so the block backs up.
            if (p == 4)
                -> hold_go;
            random_frames(PHASE_BYTES);
            settle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
